>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL of the steady voiced segment detector.
// Depends on nothing; the bodies vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/svsd_pkg.sv
// Package of the steady voiced segment detector: request types, register
// codes, reset values and the spread test. Depends on nothing.
`timescale 1ns / 1ps

package svsd_pkg;

    localparam int DEF_MAX_WINDOW = 128;
    localparam int CHAN_COUNT     = 3;
    localparam int CFG_WIDTH      = 10;
    localparam int CFG_IDX_WIDTH  = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WINDOW_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PITCH_THR      = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_F1_THR         = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_F2_THR         = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_INTENSITY  = 3'd4;

    localparam logic [7:0] RST_WINDOW_LENGTH = 8'd25;
    localparam logic [9:0] RST_PITCH_THR     = 10'd12;
    localparam logic [9:0] RST_F1_THR        = 10'd15;
    localparam logic [9:0] RST_F2_THR        = 10'd20;
    localparam logic [7:0] RST_MIN_INTENSITY = 8'd55;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam logic [6:0]  PCT_SCALE  = 7'd100;

    typedef struct packed {
        logic [31:0] frame_time_ms;
        logic [7:0]  intensity_db;
        logic [15:0] pitch_hz;
        logic [15:0] f1_hz;
        logic [15:0] f2_hz;
        logic [15:0] f3_hz;
    } t_frame;

    typedef struct packed {
        logic [31:0] segment_start_ms;
        logic [31:0] segment_end_ms;
    } t_segment;

    typedef struct packed {
        logic [CHAN_COUNT-1:0][15:0] lo;
        logic [CHAN_COUNT-1:0][15:0] hi;
        logic [31:0]                 t_start;
        logic [31:0]                 t_end;
    } t_acc;

    typedef struct packed {
        logic valid;
        t_acc acc;
    } t_tok;

    function automatic logic chan_ok(input logic [15:0] lo, input logic [15:0] hi,
                                     input logic [9:0] thr);
        logic [25:0] lhs;
        logic [25:0] rhs;
        lhs = 26'(PCT_SCALE) * 26'(hi - lo);
        rhs = 26'(thr) * 26'(lo);
        if (lo == hi) begin
            return 1'b1;
        end else if (lo == 16'd0) begin
            return 1'b0;
        end else begin
            return lhs <= rhs;
        end
    endfunction

endpackage

>>> hw/rtl/svsd_if.sv
// Valid/ready channels of the detector: frame requests in, segment requests out.
// Depends on svsd_pkg for the request types.
`timescale 1ns / 1ps

interface svsd_frame_if;
    logic              valid;
    logic              ready;
    svsd_pkg::t_frame  req;
    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

interface svsd_seg_if;
    logic                valid;
    logic                ready;
    svsd_pkg::t_segment  req;
    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

>>> hw/rtl/svsd_cell.sv
// One window slot: holds a frame's pitch, first two formants and time, and folds them
// into the min/max token passing along the chain. Depends on svsd_pkg.
`timescale 1ns / 1ps

module svsd_cell #(
    parameter int MAX_WINDOW = svsd_pkg::DEF_MAX_WINDOW,
    parameter int IDX        = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0]        i_wr_slot,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]      i_len,
    input  logic [$clog2(MAX_WINDOW)-1:0]        i_cur_slot,
    input  logic [$clog2(MAX_WINDOW)-1:0]        i_oldest,
    input  svsd_pkg::t_frame                     i_frame,
    input  svsd_pkg::t_tok                       i_tok,
    output svsd_pkg::t_tok                       o_tok
);

    localparam int SW = $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);

    logic [svsd_pkg::CHAN_COUNT-1:0][15:0] r_val;
    logic [31:0]                           r_time;
    logic                                  r_vld;
    svsd_pkg::t_acc                        r_acc;
    svsd_pkg::t_acc                        n_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_slot == SW'(IDX))) begin
            r_val  <= {i_frame.f2_hz, i_frame.f1_hz, i_frame.pitch_hz};
            r_time <= i_frame.frame_time_ms;
        end
    end

    always_comb begin
        n_acc = i_tok.acc;
        if (LW'(IDX) < i_len) begin
            for (int c = 0; c < svsd_pkg::CHAN_COUNT; c++) begin
                if (r_val[c] < n_acc.lo[c]) begin
                    n_acc.lo[c] = r_val[c];
                end
                if (r_val[c] > n_acc.hi[c]) begin
                    n_acc.hi[c] = r_val[c];
                end
            end
            if (i_oldest == SW'(IDX)) begin
                n_acc.t_start = r_time;
            end
            if (i_cur_slot == SW'(IDX)) begin
                n_acc.t_end = r_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_tok.valid = r_vld;
    assign o_tok.acc   = r_acc;

endmodule

>>> hw/rtl/steady_voiced_segment_detector_top.sv
// A frame that fills the window sets r_launch; the token then walks the chain of MAX_WINDOW
// slot cells, each registering it, and a passing spread test loads the segment into r_out.
// Throughput: one frame per cycle while the window is not full; otherwise no frame is taken
// until the token has left the chain and the test ends; o_seg back-pressure can delay that.
// Reset: synchronous, active low; clears the run and write slot and loads register
// defaults. Slot contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module steady_voiced_segment_detector_top #(
    parameter int MAX_WINDOW = svsd_pkg::DEF_MAX_WINDOW
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [svsd_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [svsd_pkg::CFG_WIDTH-1:0]        i_cfg_wdata,
    svsd_frame_if.sink                            i_frame,
    svsd_seg_if.source                            o_seg
);

    localparam int SW = $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_TEST = 2'd2;

    logic [7:0]                            r_cfg_len;
    logic [svsd_pkg::CHAN_COUNT-1:0][9:0]  r_thr;
    logic [7:0]                            r_min_int;

    logic [1:0]          r_state;
    logic [LW-1:0]       r_run;
    logic [SW-1:0]       r_wslot;
    logic [SW-1:0]       r_cur_slot;
    logic [SW-1:0]       r_oldest;
    logic                r_launch;
    logic                r_out_vld;
    svsd_pkg::t_segment  r_out;

    logic [LW-1:0]       len;
    logic [SW-1:0]       slot;
    logic [LW-1:0]       slot_p1;
    logic [SW-1:0]       next_slot;
    logic [LW-1:0]       run_new;
    logic                voiced;
    logic                accept;
    logic                pass;
    logic                load_out;
    svsd_pkg::t_tok      w_chain [0:MAX_WINDOW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= svsd_pkg::RST_WINDOW_LENGTH;
            r_thr     <= {svsd_pkg::RST_F2_THR, svsd_pkg::RST_F1_THR, svsd_pkg::RST_PITCH_THR};
            r_min_int <= svsd_pkg::RST_MIN_INTENSITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                svsd_pkg::CFG_WINDOW_LENGTH: r_cfg_len <= i_cfg_wdata[7:0];
                svsd_pkg::CFG_PITCH_THR:     r_thr[0]  <= i_cfg_wdata;
                svsd_pkg::CFG_F1_THR:        r_thr[1]  <= i_cfg_wdata;
                svsd_pkg::CFG_F2_THR:        r_thr[2]  <= i_cfg_wdata;
                svsd_pkg::CFG_MIN_INTENSITY: r_min_int <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_cfg_len == 8'd0) begin
            len = LW'(1);
        end else if (32'(r_cfg_len) > 32'(MAX_WINDOW)) begin
            len = LW'(MAX_WINDOW);
        end else begin
            len = LW'(r_cfg_len);
        end
    end

    assign accept    = i_frame.valid && i_frame.ready;
    assign slot      = (LW'(r_wslot) >= len) ? '0 : r_wslot;
    assign slot_p1   = LW'(slot) + LW'(1);
    assign next_slot = (slot_p1 >= len) ? '0 : SW'(slot_p1);
    assign voiced    = (i_frame.req.intensity_db >= r_min_int) &&
                       (i_frame.req.pitch_hz != 16'd0) && (i_frame.req.f3_hz != 16'd0);
    assign run_new   = voiced ? (r_run + LW'(1)) : '0;

    assign w_chain[0].valid       = r_launch;
    assign w_chain[0].acc.lo      = {svsd_pkg::CHAN_COUNT{svsd_pkg::FULL_SCALE}};
    assign w_chain[0].acc.hi      = '0;
    assign w_chain[0].acc.t_start = '0;
    assign w_chain[0].acc.t_end   = '0;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        svsd_cell #(
            .MAX_WINDOW(MAX_WINDOW),
            .IDX(g)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_wr_en(accept),
            .i_wr_slot(slot),
            .i_len(len),
            .i_cur_slot(r_cur_slot),
            .i_oldest(r_oldest),
            .i_frame(i_frame.req),
            .i_tok(w_chain[g]),
            .o_tok(w_chain[g+1])
        );
    end

    assign pass = svsd_pkg::chan_ok(w_chain[MAX_WINDOW].acc.lo[0],
                                    w_chain[MAX_WINDOW].acc.hi[0], r_thr[0]) &&
                  svsd_pkg::chan_ok(w_chain[MAX_WINDOW].acc.lo[1],
                                    w_chain[MAX_WINDOW].acc.hi[1], r_thr[1]) &&
                  svsd_pkg::chan_ok(w_chain[MAX_WINDOW].acc.lo[2],
                                    w_chain[MAX_WINDOW].acc.hi[2], r_thr[2]);

    assign load_out = (r_state == ST_TEST) && pass && (!r_out_vld || o_seg.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_run      <= '0;
            r_wslot    <= '0;
            r_cur_slot <= '0;
            r_oldest   <= '0;
            r_launch   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_launch  <= (r_state == ST_IDLE) && accept && (run_new >= len);
            r_out_vld <= load_out || (r_out_vld && !o_seg.ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_wslot    <= next_slot;
                        r_cur_slot <= slot;
                        r_oldest   <= next_slot;
                        r_run      <= run_new;
                        if (run_new >= len) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_chain[MAX_WINDOW].valid) begin
                        r_state <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    if (!pass) begin
                        r_run   <= len - LW'(1);
                        r_state <= ST_IDLE;
                    end else if (!r_out_vld || o_seg.ready) begin
                        r_run   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.segment_start_ms <= w_chain[MAX_WINDOW].acc.t_start;
            r_out.segment_end_ms   <= w_chain[MAX_WINDOW].acc.t_end;
        end
    end

    assign i_frame.ready = (r_state == ST_IDLE);
    assign o_seg.valid   = r_out_vld;
    assign o_seg.req     = r_out;

    `ASSERT_IMPLIES(a_tok_from_launch, i_clk, i_rst_n, w_chain[MAX_WINDOW].valid, $past(r_launch, MAX_WINDOW))
    `ASSERT_IMPLIES(a_tok_in_scan, i_clk, i_rst_n, w_chain[MAX_WINDOW].valid, r_state == ST_SCAN)
    `ASSERT_IMPLIES(a_out_from_test, i_clk, i_rst_n, $rose(r_out_vld), $past(r_state) == ST_TEST)
    `ASSERT_NEXT(a_launch_scans, i_clk, i_rst_n, r_launch, r_state == ST_SCAN)

endmodule

>>> verif/tb_top.sv
// Self-checking bench for steady_voiced_segment_detector_top: random and directed frame
// requests, a frame-level predictor of the detector and an in-order segment scoreboard.
// Depends on svsd_pkg, svsd_if.sv and the detector RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned MAX_WIN = svsd_pkg::DEF_MAX_WINDOW;
    localparam int unsigned SETTLE_CYCLES = MAX_WIN + 16;
    localparam int unsigned RANDOM_FRAMES = 2000;
    localparam int unsigned HOLD_AT = 1750;
    localparam int unsigned HOLD_LEN = 2000;
    localparam longint unsigned LIMIT_CYCLES = 3_000_000;
    localparam longint unsigned PCT = 100;

    typedef struct {
        bit               drain;
        svsd_pkg::t_frame fr;
    } t_pending;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [svsd_pkg::CFG_IDX_WIDTH-1:0] cfg_idx;
    logic [svsd_pkg::CFG_WIDTH-1:0] cfg_wdata;

    svsd_frame_if frm_ch ();
    svsd_seg_if   seg_ch ();

    steady_voiced_segment_detector_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_frame     (frm_ch),
        .o_seg       (seg_ch)
    );

    t_pending pending_frames[$];
    svsd_pkg::t_segment expected_segments[$];
    t_pending nxt;
    svsd_pkg::t_segment got_seg;
    svsd_pkg::t_segment want;

    logic [15:0] chan_hist [3][MAX_WIN];
    logic [31:0] time_hist [MAX_WIN];
    int unsigned voiced_run;
    int unsigned next_slot;
    logic [7:0] cfg_len;
    logic [9:0] cfg_thr [3];
    logic [7:0] cfg_min_int;

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned frames_queued;
    int unsigned frames_taken;
    int unsigned hold_left;
    bit hold_done;
    int unsigned errors;
    longint unsigned cycles;
    logic [31:0] t_clock;

    always #5 clk = ~clk;

    function automatic int unsigned eff_len();
        if (cfg_len == 0) return 1;
        if (cfg_len > MAX_WIN) return MAX_WIN;
        return cfg_len;
    endfunction

    function automatic bit predict_segment(input svsd_pkg::t_frame fr,
                                           output svsd_pkg::t_segment found);
        int unsigned n;
        int unsigned slot;
        int unsigned oldest;
        logic [15:0] lo;
        logic [15:0] hi;
        bit steady;
        n = eff_len();
        found = '0;
        if (next_slot >= n) next_slot = 0;
        slot = next_slot;
        chan_hist[0][slot] = fr.pitch_hz;
        chan_hist[1][slot] = fr.f1_hz;
        chan_hist[2][slot] = fr.f2_hz;
        time_hist[slot] = fr.frame_time_ms;
        if (voiced_run < 32'hFFFF) voiced_run++;
        if (fr.intensity_db < cfg_min_int || fr.pitch_hz == 0 || fr.f3_hz == 0) voiced_run = 0;
        steady = 1'b0;
        if (voiced_run >= n) begin
            steady = 1'b1;
            for (int c = 0; c < 3; c++) begin
                lo = '1;
                hi = '0;
                for (int k = 0; k < n; k++) begin
                    if (chan_hist[c][k] < lo) lo = chan_hist[c][k];
                    if (chan_hist[c][k] > hi) hi = chan_hist[c][k];
                end
                if (lo != hi && (lo == 0 ||
                        PCT * 64'(hi - lo) > 64'(cfg_thr[c]) * 64'(lo))) begin
                    steady = 1'b0;
                end
            end
            if (steady) begin
                oldest = (slot + 1 >= n) ? 0 : slot + 1;
                found.segment_start_ms = time_hist[oldest];
                found.segment_end_ms = time_hist[slot];
                voiced_run = 0;
            end else begin
                voiced_run = n - 1;
            end
        end
        next_slot = (slot + 1 >= n) ? 0 : slot + 1;
        return steady;
    endfunction

    task automatic push_frame(input logic [31:0] t, input logic [7:0] inten,
                              input logic [15:0] p, input logic [15:0] f1,
                              input logic [15:0] f2, input logic [15:0] f3);
        t_pending item;
        item.drain = 1'b0;
        item.fr.frame_time_ms = t;
        item.fr.intensity_db = inten;
        item.fr.pitch_hz = p;
        item.fr.f1_hz = f1;
        item.fr.f2_hz = f2;
        item.fr.f3_hz = f3;
        pending_frames.push_back(item);
        frames_queued++;
    endtask

    task automatic write_reg(input logic [svsd_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [9:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        case (idx)
            svsd_pkg::CFG_WINDOW_LENGTH: cfg_len = val[7:0];
            svsd_pkg::CFG_PITCH_THR:     cfg_thr[0] = val;
            svsd_pkg::CFG_F1_THR:        cfg_thr[1] = val;
            svsd_pkg::CFG_F2_THR:        cfg_thr[2] = val;
            svsd_pkg::CFG_MIN_INTENSITY: cfg_min_int = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] len, input logic [9:0] p_thr,
                                 input logic [9:0] f1_thr, input logic [9:0] f2_thr,
                                 input logic [7:0] min_int);
        write_reg(svsd_pkg::CFG_WINDOW_LENGTH, {2'b00, len});
        write_reg(svsd_pkg::CFG_PITCH_THR, p_thr);
        write_reg(svsd_pkg::CFG_F1_THR, f1_thr);
        write_reg(svsd_pkg::CFG_F2_THR, f2_thr);
        write_reg(svsd_pkg::CFG_MIN_INTENSITY, {2'b00, min_int});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (pending_frames.size() != 0 || frm_ch.valid) @(posedge clk);
        @(posedge clk);
        while (expected_segments.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [9:0] pick_thr();
        case ($urandom_range(9))
            0: return 10'd0;
            1: return 10'd1000;
            2: return 10'd1023;
            default: return 10'($urandom_range(5, 60));
        endcase
    endfunction

    task automatic pick_settings();
        logic [7:0] len;
        logic [7:0] min_int;
        case ($urandom_range(19))
            0: len = 8'd0;
            1: len = 8'd1;
            2: len = 8'd255;
            3: len = 8'd128;
            4: len = 8'($urandom_range(9, 40));
            default: len = 8'($urandom_range(2, 8));
        endcase
        case ($urandom_range(9))
            0: min_int = 8'd0;
            1: min_int = 8'd255;
            default: min_int = 8'($urandom_range(30, 90));
        endcase
        load_settings(len, pick_thr(), pick_thr(), pick_thr(), min_int);
    endtask

    task automatic push_sequence();
        t_pending marker;
        int unsigned n;
        int unsigned kind;
        int unsigned len;
        int unsigned brk;
        int unsigned base [3];
        int unsigned span [3];
        int unsigned val [3];
        int unsigned inten;
        int unsigned f3;
        bit wide;
        n = eff_len();
        if ($urandom_range(24) == 0) begin
            marker.drain = 1'b1;
            marker.fr = '0;
            pending_frames.push_back(marker);
        end
        kind = $urandom_range(99);
        if (kind >= 85) begin
            repeat ($urandom_range(1, 4)) begin
                push_frame($urandom, 8'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
            end
            return;
        end
        len = n + $urandom_range(0, n);
        if ($urandom_range(3) == 0) len = $urandom_range(1, n);
        brk = (kind >= 65) ? $urandom_range(0, len - 1) : len;
        wide = ($urandom_range(4) == 0);
        if ($urandom_range(9) == 0) t_clock = $urandom;
        for (int c = 0; c < 3; c++) begin
            case ($urandom_range(19))
                0: base[c] = (c == 0) ? 1 : 0;
                1: base[c] = $urandom_range(1, 65535);
                default: begin
                    case (c)
                        0: base[c] = $urandom_range(60, 800);
                        1: base[c] = $urandom_range(200, 1000);
                        default: base[c] = $urandom_range(700, 3000);
                    endcase
                end
            endcase
            span[c] = base[c] * cfg_thr[c] / 100;
            if (wide) span[c] = span[c] * 2 + 3;
            if (span[c] > 65535 - base[c]) span[c] = 65535 - base[c];
        end
        for (int i = 0; i < len; i++) begin
            for (int c = 0; c < 3; c++) val[c] = base[c] + $urandom_range(0, span[c]);
            inten = $urandom_range(cfg_min_int, 255);
            f3 = $urandom_range(1, 65535);
            if (i == brk) begin
                case ($urandom_range(2))
                    0: begin
                        if (cfg_min_int > 0) inten = $urandom_range(0, cfg_min_int - 1);
                        else val[0] = 0;
                    end
                    1: val[0] = 0;
                    default: f3 = 0;
                endcase
            end
            t_clock = t_clock + $urandom_range(1, 40);
            push_frame(t_clock, 8'(inten), 16'(val[0]), 16'(val[1]), 16'(val[2]), 16'(f3));
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            frm_ch.valid <= 1'b0;
        end else if (!frm_ch.valid || frm_ch.ready) begin
            if (pending_frames.size() != 0 && pending_frames[0].drain) begin
                frm_ch.valid <= 1'b0;
                if (!frm_ch.valid && expected_segments.size() == 0) begin
                    nxt = pending_frames.pop_front();
                end
            end else if (pending_frames.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = pending_frames.pop_front();
                frm_ch.valid <= 1'b1;
                frm_ch.req <= nxt.fr;
            end else begin
                frm_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && frm_ch.valid && frm_ch.ready) begin
            if (predict_segment(frm_ch.req, got_seg)) expected_segments.push_back(got_seg);
            frames_taken <= frames_taken + 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            seg_ch.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && frames_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            seg_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            seg_ch.ready <= 1'b0;
        end else begin
            seg_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && seg_ch.valid && seg_ch.ready) begin
            if (expected_segments.size() == 0) begin
                $error("segment with no pending expectation: start %0h end %0h",
                       seg_ch.req.segment_start_ms, seg_ch.req.segment_end_ms);
                errors++;
            end else begin
                want = expected_segments.pop_front();
                if (seg_ch.req.segment_start_ms !== want.segment_start_ms) begin
                    $error("segment_start_ms: expected %0h, got %0h",
                           want.segment_start_ms, seg_ch.req.segment_start_ms);
                    errors++;
                end
                if (seg_ch.req.segment_end_ms !== want.segment_end_ms) begin
                    $error("segment_end_ms: expected %0h, got %0h",
                           want.segment_end_ms, seg_ch.req.segment_end_ms);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned random_base;
        int unsigned phase_end;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = svsd_pkg::CFG_WINDOW_LENGTH;
        cfg_wdata = '0;
        frm_ch.valid = 1'b0;
        frm_ch.req = '0;
        seg_ch.ready = 1'b0;
        cfg_len = svsd_pkg::RST_WINDOW_LENGTH;
        cfg_thr[0] = svsd_pkg::RST_PITCH_THR;
        cfg_thr[1] = svsd_pkg::RST_F1_THR;
        cfg_thr[2] = svsd_pkg::RST_F2_THR;
        cfg_min_int = svsd_pkg::RST_MIN_INTENSITY;
        voiced_run = 0;
        next_slot = 0;
        frames_queued = 0;
        frames_taken = 0;
        errors = 0;
        cycles = 0;
        t_clock = '0;
        src_idle_pct = 6;
        snk_idle_pct = 86;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, every channel spread exactly at its limit.
        for (int i = 0; i < 25; i++) begin
            push_frame(32'(i * 10), 8'd55, (i % 2) ? 16'd224 : 16'd200,
                       (i % 2) ? 16'd575 : 16'd500, (i % 2) ? 16'd1200 : 16'd1000, 16'd2500);
        end
        settle();

        // The largest window also writes every slot once.
        load_settings(8'd128, 10'd1023, 10'd1023, 10'd1023, 8'd0);
        for (int i = 0; i < 128; i++) begin
            push_frame(32'hFFFF_FF80 + 32'(i), 8'hFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        end
        settle();

        load_settings(8'd0, 10'd0, 10'd0, 10'd0, 8'd255);
        push_frame(32'd1, 8'd255, 16'd1, 16'd1, 16'd1, 16'd1);
        push_frame(32'd2, 8'd254, 16'd1, 16'd1, 16'd1, 16'd1);
        push_frame(32'd3, 8'd255, 16'd0, 16'd1, 16'd1, 16'd1);
        push_frame(32'd4, 8'd255, 16'd1, 16'd1, 16'd1, 16'd0);
        settle();

        load_settings(8'd2, 10'd10, 10'd10, 10'd10, 8'd0);
        push_frame(32'd100, 8'd0, 16'd100, 16'd300, 16'd900, 16'd2000);
        push_frame(32'd110, 8'd0, 16'd110, 16'd300, 16'd900, 16'd2000);
        push_frame(32'd120, 8'd0, 16'd100, 16'd300, 16'd900, 16'd2000);
        push_frame(32'd130, 8'd0, 16'd111, 16'd300, 16'd900, 16'd2000);
        push_frame(32'd140, 8'd0, 16'd111, 16'd300, 16'd900, 16'd2000);
        push_frame(32'd150, 8'd0, 16'd200, 16'd0, 16'd900, 16'd2000);
        push_frame(32'd160, 8'd0, 16'd200, 16'd7, 16'd900, 16'd2000);
        push_frame(32'd170, 8'd0, 16'd200, 16'd7, 16'd900, 16'd2000);
        settle();

        random_base = frames_queued;
        while (frames_queued - random_base < RANDOM_FRAMES) begin
            if (frames_queued - random_base < RANDOM_FRAMES / 3) begin
                src_idle_pct = 6;
                snk_idle_pct = 86;
            end else if (frames_queued - random_base < 2 * RANDOM_FRAMES / 3) begin
                src_idle_pct = 86;
                snk_idle_pct = 6;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            pick_settings();
            phase_end = frames_queued + $urandom_range(60, 160);
            while (frames_queued < phase_end &&
                   frames_queued - random_base < RANDOM_FRAMES) begin
                push_sequence();
            end
            settle();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> steady_voiced_segment_detector_top.f
+incdir+hw/rtl
hw/rtl/svsd_pkg.sv
hw/rtl/svsd_if.sv
hw/rtl/svsd_cell.sv
hw/rtl/steady_voiced_segment_detector_top.sv
verif/tb_top.sv
